### design/bvh_pkg.sv
package bvh_pkg;

  localparam logic [1:0] OP_LOAD_LO = 2'd0;
  localparam logic [1:0] OP_LOAD_HI = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [1:0] REG_VERTEX_NODES = 2'd0;
  localparam logic [1:0] REG_EDGE_NODES   = 2'd1;
  localparam logic [1:0] REG_FACE_NODES   = 2'd2;

  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 7;
  localparam int PRIM_W      = 20;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [1:0]          tree_select;
    logic [6:0]          node_index;
    logic signed [31:0]  coord_x;
    logic signed [31:0]  coord_y;
    logic signed [31:0]  coord_z;
    logic [PRIM_W-1:0]   left_or_primitive;
    logic [6:0]          right_link;
    logic                leaf_flag;
    logic [29:0]         query_radius;
  } in_word_t;

  typedef struct packed {
    logic              hit_valid;
    logic [PRIM_W-1:0] prim_id;
    logic              last;
    logic              stack_overflow;
  } out_word_t;

endpackage

### design/bvh_box_overlap_query_core.sv
// Box-overlap query engine over three node stores (vertex, edge, face tree).
// Load words (opcodes 0 and 1) produce nothing. A query word forms the cube
// point +/- radius and walks the selected tree from slot zero, one node store
// read per cycle: each expansion step runs node read, links, left and right
// child as needed, and decide, plus a stack pop, up to TREE_NODES steps, all
// through the single read port of the node store. Hits collect in a 64-entry
// buffer and stream out afterward (buffer read, then output load once the
// output register is free), because the stack_overflow flag on every word is
// known only at the end of the walk. A query with no hit returns one word with
// hit_valid low. in_ready is high only between queries.
module bvh_box_overlap_query_core #(
  parameter int TREE_NODES  = 127,
  parameter int STACK_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bvh_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bvh_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_wdata
);
  import bvh_pkg::*;

  localparam int DEPTH = 3 * TREE_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
  localparam int NW    = $clog2(TREE_NODES + 1);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int SPI   = $clog2(STACK_DEPTH);
  localparam int HCW   = $clog2(MAX_RESULTS + 1);
  localparam int HIW   = $clog2(MAX_RESULTS);
  localparam int LO_W  = 96 + 28;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_ROOT  = 4'd2;
  localparam logic [3:0] S_NODE  = 4'd3;
  localparam logic [3:0] S_LINK  = 4'd4;
  localparam logic [3:0] S_LEFT  = 4'd5;
  localparam logic [3:0] S_RIGHT = 4'd6;
  localparam logic [3:0] S_DEC   = 4'd7;
  localparam logic [3:0] S_POP   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUTRD = 4'd10;
  localparam logic [3:0] S_OUTLD = 4'd11;

  logic [3:0] state_r, state_nxt;

  // config
  logic [CNT_W-1:0] cnt_r [3];

  // node stores: low corner plus links, high corner
  logic [LO_W-1:0] mem_lo [DEPTH];
  logic [95:0]     mem_hi [DEPTH];
  logic [LO_W-1:0] lo_q;
  logic [95:0]     hi_q;
  logic [AW-1:0]   rd_addr;

  logic [IW-1:0]  stack_mem [STACK_DEPTH];
  logic [IW-1:0]  stk_q;
  logic [PRIM_W-1:0] hit_buf [MAX_RESULTS];
  logic [PRIM_W-1:0] hit_q;

  // query context
  logic signed [33:0] qlo_x_r, qlo_y_r, qlo_z_r, qhi_x_r, qhi_y_r, qhi_z_r;
  logic [NW-1:0]      n_r;
  logic [AW-1:0]      base_r;
  logic [IW-1:0]      node_r, node_nxt;
  logic [PRIM_W-1:0]  l_r;
  logic [6:0]         rl_r;
  logic               tl_r, tl_nxt, tr_r, tr_nxt;
  logic [NW-1:0]      steps_r, steps_nxt;
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic               ovf_r, ovf_nxt;
  logic [HCW-1:0]     hcnt_r, hcnt_nxt;
  logic [HCW-1:0]     oidx_r, oidx_nxt;
  logic               out_valid_r;
  out_word_t          out_r;

  logic               push, hit_we;
  logic               ov, leaf;
  logic               r_ok;
  logic               out_free;
  logic               load_out;
  out_word_t          out_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // cube overlap against the word just read
  always_comb begin
    logic signed [33:0] mnx, mny, mnz, mxx, mxy, mxz;
    mnx = 34'(signed'(lo_q[123:92]));
    mny = 34'(signed'(lo_q[91:60]));
    mnz = 34'(signed'(lo_q[59:28]));
    mxx = 34'(signed'(hi_q[95:64]));
    mxy = 34'(signed'(hi_q[63:32]));
    mxz = 34'(signed'(hi_q[31:0]));
    ov = (mnx <= qhi_x_r) && (qlo_x_r <= mxx) &&
         (mny <= qhi_y_r) && (qlo_y_r <= mxy) &&
         (mnz <= qhi_z_r) && (qlo_z_r <= mxz);
    leaf = lo_q[0];
  end

  assign r_ok = (rl_r < 7'(n_r));

  always_comb begin
    state_nxt = state_r;
    node_nxt  = node_r;
    tl_nxt    = tl_r;
    tr_nxt    = tr_r;
    steps_nxt = steps_r;
    sp_nxt    = sp_r;
    ovf_nxt   = ovf_r;
    hcnt_nxt  = hcnt_r;
    oidx_nxt  = oidx_r;
    rd_addr   = base_r + AW'(node_r);
    push      = 1'b0;
    hit_we    = 1'b0;
    load_out  = 1'b0;
    out_nxt   = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_data.opcode == OP_QUERY) begin
          state_nxt = S_START;
          sp_nxt    = '0;
          ovf_nxt   = 1'b0;
          hcnt_nxt  = '0;
          steps_nxt = '0;
          node_nxt  = '0;
        end
      end
      S_START: begin
        rd_addr   = base_r;
        state_nxt = (n_r == '0) ? S_FIN : S_ROOT;
      end
      S_ROOT: begin
        if (n_r == NW'(1) || leaf) begin
          if (ov) hit_we = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        rd_addr   = base_r + AW'(node_r);
        state_nxt = (steps_r == NW'(TREE_NODES)) ? S_FIN : S_LINK;
      end
      S_LINK: begin
        tl_nxt = 1'b0;
        tr_nxt = 1'b0;
        if (lo_q[20:1] < PRIM_W'(n_r)) begin
          rd_addr   = base_r + AW'(lo_q[IW:1]);
          state_nxt = S_LEFT;
        end else if (lo_q[27:21] < 7'(n_r)) begin
          rd_addr   = base_r + AW'(lo_q[21+IW-1:21]);
          state_nxt = S_RIGHT;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_LEFT: begin
        if (ov && leaf) hit_we = 1'b1;
        if (ov && !leaf) tl_nxt = 1'b1;
        if (r_ok) begin
          rd_addr   = base_r + AW'(rl_r[IW-1:0]);
          state_nxt = S_RIGHT;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_RIGHT: begin
        if (ov && leaf) hit_we = 1'b1;
        if (ov && !leaf) tr_nxt = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        steps_nxt = steps_r + NW'(1);
        if (!tl_r && !tr_r) begin
          if (sp_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            sp_nxt    = sp_r - SPW'(1);
            state_nxt = S_POP;
          end
        end else begin
          node_nxt  = tl_r ? l_r[IW-1:0] : rl_r[IW-1:0];
          state_nxt = S_NODE;
          if (tl_r && tr_r) begin
            if (sp_r < SPW'(STACK_DEPTH)) begin
              push   = 1'b1;
              sp_nxt = sp_r + SPW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
      end
      S_POP: begin
        node_nxt  = stk_q;
        state_nxt = S_NODE;
      end
      S_FIN: begin
        oidx_nxt = '0;
        if (hcnt_r != '0) begin
          state_nxt = S_OUTRD;
        end else if (out_free) begin
          load_out  = 1'b1;
          out_nxt   = '{hit_valid: 1'b0, prim_id: '0, last: 1'b1,
                        stack_overflow: ovf_r};
          state_nxt = S_IDLE;
        end
      end
      S_OUTRD: begin
        state_nxt = S_OUTLD;
      end
      S_OUTLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          out_nxt   = '{hit_valid: 1'b1, prim_id: hit_q,
                        last: (oidx_r + HCW'(1) == hcnt_r), stack_overflow: ovf_r};
          oidx_nxt  = oidx_r + HCW'(1);
          state_nxt = (oidx_r + HCW'(1) == hcnt_r) ? S_IDLE : S_OUTRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (hit_we) begin
      if (hcnt_r < HCW'(MAX_RESULTS)) hcnt_nxt = hcnt_r + HCW'(1);
      else hit_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      cnt_r[2]    <= '0;
      sp_r        <= '0;
      ovf_r       <= 1'b0;
      hcnt_r      <= '0;
      oidx_r      <= '0;
      steps_r     <= '0;
      node_r      <= '0;
      tl_r        <= 1'b0;
      tr_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      ovf_r   <= ovf_nxt;
      hcnt_r  <= hcnt_nxt;
      oidx_r  <= oidx_nxt;
      steps_r <= steps_nxt;
      node_r  <= node_nxt;
      tl_r    <= tl_nxt;
      tr_r    <= tr_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VERTEX_NODES: cnt_r[0] <= cfg_wdata;
          REG_EDGE_NODES:   cnt_r[1] <= cfg_wdata;
          REG_FACE_NODES:   cnt_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // query setup and payload registers
  always_ff @(posedge clk) begin
    logic signed [33:0] rad;
    logic [CNT_W-1:0]   c;
    rad = 34'(signed'({1'b0, in_data.query_radius}));
    c   = '0;
    if (load_out) out_r <= out_nxt;
    if (state_r == S_LINK) begin
      l_r  <= lo_q[20:1];
      rl_r <= lo_q[27:21];
    end
    if (state_r == S_IDLE && in_valid && in_data.opcode == OP_QUERY) begin
      qlo_x_r <= 34'(in_data.coord_x) - rad;
      qhi_x_r <= 34'(in_data.coord_x) + rad;
      qlo_y_r <= 34'(in_data.coord_y) - rad;
      qhi_y_r <= 34'(in_data.coord_y) + rad;
      qlo_z_r <= 34'(in_data.coord_z) - rad;
      qhi_z_r <= 34'(in_data.coord_z) + rad;
      if (in_data.tree_select <= 2'd2) c = cnt_r[in_data.tree_select];
      n_r    <= (c > CNT_W'(TREE_NODES)) ? NW'(TREE_NODES) : NW'(c);
      base_r <= AW'(in_data.tree_select) * AW'(TREE_NODES);
    end
  end

  // node store write/read
  always_ff @(posedge clk) begin
    logic [AW-1:0] wa;
    wa = AW'(in_data.tree_select) * AW'(TREE_NODES) + AW'(in_data.node_index);
    if (state_r == S_IDLE && in_valid && in_data.tree_select <= 2'd2 &&
        in_data.node_index < 7'(TREE_NODES)) begin
      if (in_data.opcode == OP_LOAD_LO)
        mem_lo[wa] <= {in_data.coord_x, in_data.coord_y, in_data.coord_z,
                       in_data.right_link, in_data.left_or_primitive, in_data.leaf_flag};
      if (in_data.opcode == OP_LOAD_HI)
        mem_hi[wa] <= {in_data.coord_x, in_data.coord_y, in_data.coord_z};
    end
    lo_q <= mem_lo[rd_addr];
    hi_q <= mem_hi[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (push) stack_mem[sp_r[SPI-1:0]] <= rl_r[IW-1:0];
    stk_q <= stack_mem[sp_nxt[SPI-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hit_we) hit_buf[hcnt_r[HIW-1:0]] <= lo_q[20:1];
    hit_q <= hit_buf[oidx_r[HIW-1:0]];
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
  a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= HCW'(MAX_RESULTS)) else $error("hit count beyond buffer");
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= NW'(TREE_NODES)) else $error("walk step count overrun");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.opcode == OP_QUERY) |=> !in_ready)
    else $error("query did not start");
  a_push_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (sp_r < SPW'(STACK_DEPTH))) else $error("push into full stack");

endmodule

### dv/tb_bvh_box_overlap_query_core.sv
module tb_bvh_box_overlap_query_core;
  import bvh_pkg::*;

  // Local names for codes the package leaves out.
  localparam logic [1:0] OP_NONE   = 2'd3;  // unused opcode, dropped by the block
  localparam logic [1:0] TREE_V    = 2'd0;
  localparam logic [1:0] TREE_E    = 2'd1;
  localparam logic [1:0] TREE_F    = 2'd2;
  localparam logic [1:0] TREE_NONE = 2'd3;  // no such tree
  localparam int NODES     = 127;
  localparam int STACK_D   = 64;
  localparam int ITEM_CNT  = 280;
  localparam int BIG_TREE  = 31;            // larger heap tree in some phases
  localparam int HOLD_LEN  = 400;           // long receiver back-pressure stretch
  localparam int DRAIN_CYC = 8;             // margin only
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;
  localparam logic [29:0] R_MAX = 30'h3fff_ffff;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_wdata;

  bvh_box_overlap_query_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the node stores, node counts and traversal stack.
  // Box corners are kept in 64-bit so the query cube never wraps.
  // ---------------------------------------------------------------------------
  longint      lo_x [0:3*NODES-1];
  longint      lo_y [0:3*NODES-1];
  longint      lo_z [0:3*NODES-1];
  longint      hi_x [0:3*NODES-1];
  longint      hi_y [0:3*NODES-1];
  longint      hi_z [0:3*NODES-1];
  logic [27:0] node_lk [0:3*NODES-1];  // bit 0 leaf, 20:1 left/prim, 27:21 right
  logic [6:0]  walk_stack [0:STACK_D-1];
  int          node_cnt [0:2];
  longint      cube_lo_x, cube_lo_y, cube_lo_z, cube_hi_x, cube_hi_y, cube_hi_z;

  out_word_t   pending_hits [$];  // results still owed by the block

  int errors, n_queries, n_words, n_results, n_hits, n_ovf;
  int send_idle, recv_idle;      // idle percentages for sender / receiver
  bit hold_req;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic bit cube_hits(input int slot);
    return lo_x[slot] <= cube_hi_x && cube_lo_x <= hi_x[slot] &&
           lo_y[slot] <= cube_hi_y && cube_lo_y <= hi_y[slot] &&
           lo_z[slot] <= cube_hi_z && cube_lo_z <= hi_z[slot];
  endfunction

  // Updates the shadow stores for loads, returns the result words of a query.
  function automatic void predict_word(input in_word_t w, ref out_word_t res[$]);
    int k, n, base, node, steps, sp, l, r;
    longint rad;
    bit ovf, tl, tr;
    logic [19:0] ids [$];
    out_word_t o;
    res.delete();
    ovf = 1'b0;
    if (w.opcode == OP_LOAD_LO || w.opcode == OP_LOAD_HI) begin
      if (w.tree_select > TREE_F || w.node_index >= NODES) return;
      k = w.tree_select * NODES + w.node_index;
      if (w.opcode == OP_LOAD_LO) begin
        lo_x[k] = longint'(w.coord_x);
        lo_y[k] = longint'(w.coord_y);
        lo_z[k] = longint'(w.coord_z);
        node_lk[k] = {w.right_link, w.left_or_primitive, w.leaf_flag};
      end else begin
        hi_x[k] = longint'(w.coord_x);
        hi_y[k] = longint'(w.coord_y);
        hi_z[k] = longint'(w.coord_z);
      end
      return;
    end
    if (w.opcode != OP_QUERY) return;

    rad = longint'({1'b0, w.query_radius});
    cube_lo_x = longint'(w.coord_x) - rad;  cube_hi_x = longint'(w.coord_x) + rad;
    cube_lo_y = longint'(w.coord_y) - rad;  cube_hi_y = longint'(w.coord_y) + rad;
    cube_lo_z = longint'(w.coord_z) - rad;  cube_hi_z = longint'(w.coord_z) + rad;
    n = 0;
    base = 0;
    if (w.tree_select <= TREE_F) begin
      n = node_cnt[w.tree_select];
      base = w.tree_select * NODES;
    end

    if (n == 1 || (n > 1 && node_lk[base][0])) begin
      // lone root, or a leaf at the root: only the root is tested
      if (cube_hits(base)) ids = {ids, node_lk[base][20:1]};
    end else if (n > 1) begin
      node = 0;
      sp = 0;
      for (steps = 0; steps < NODES; steps++) begin
        l = node_lk[base + node][20:1];
        r = node_lk[base + node][27:21];
        tl = 1'b0;
        tr = 1'b0;
        if (l < n && cube_hits(base + l)) begin
          if (node_lk[base + l][0]) ids = {ids, node_lk[base + l][20:1]};
          else tl = 1'b1;
        end
        if (r < n && cube_hits(base + r)) begin
          if (node_lk[base + r][0]) ids = {ids, node_lk[base + r][20:1]};
          else tr = 1'b1;
        end
        if (!tl && !tr) begin
          if (sp == 0) break;
          sp--;
          node = walk_stack[sp];
        end else begin
          node = tl ? l : r;
          if (tl && tr) begin
            if (sp < STACK_D) begin
              walk_stack[sp] = 7'(r);
              sp++;
            end else begin
              ovf = 1'b1;  // stack full: right subtree is lost
            end
          end
        end
      end
    end

    if (ids.size() > MAX_RESULTS) ids = ids[0:MAX_RESULTS-1];
    if (ids.size() == 0) begin
      o = '{hit_valid: 1'b0, prim_id: '0, last: 1'b1, stack_overflow: ovf};
      res = {res, o};
    end else begin
      foreach (ids[i]) begin
        o = '{hit_valid: 1'b1, prim_id: ids[i], last: (i == ids.size() - 1),
              stack_overflow: ovf};
        res = {res, o};
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Called at a rising edge; returns at the edge that took the word.
  // valid is only dropped when an idle gap is inserted.
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t exp);
    out_word_t res [$];
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_word(w, res);
    n_words++;
    if (w.opcode == OP_QUERY) n_queries++;
    if (typed) pending_hits = {pending_hits, exp};
    else pending_hits = {pending_hits, res};
    // idle profile follows overall progress
    if (n_words > 2 * ITEM_CNT / 3) begin
      send_idle = 0;
      recv_idle = 0;
    end else if (n_words > ITEM_CNT / 3) begin
      send_idle = 56;
      recv_idle = 11;
    end
  endtask

  // Register writes happen only with the block drained.
  task automatic write_count(input logic [1:0] idx, input logic [6:0] val);
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_cnt[idx] = val;
  endtask

  function automatic in_word_t mk(input logic [1:0] op, input logic [1:0] tree,
                                  input logic [6:0] idx, input logic signed [31:0] x,
                                  input logic signed [31:0] y, input logic signed [31:0] z,
                                  input logic [19:0] lp, input logic [6:0] rl,
                                  input logic leaf, input logic [29:0] rad);
    in_word_t w;
    w.opcode = op;          w.tree_select = tree;     w.node_index = idx;
    w.coord_x = x;          w.coord_y = y;            w.coord_z = z;
    w.left_or_primitive = lp; w.right_link = rl;      w.leaf_flag = leaf;
    w.query_radius = rad;
    return w;
  endfunction

  // Directed table: a register write or a word, optionally with a typed result.
  typedef struct {
    bit         is_cfg;
    logic [1:0] reg_idx;
    logic [6:0] reg_val;
    in_word_t   w;
    bit         typed;
    out_word_t  exp;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_word(input in_word_t w, input bit typed = 1'b0,
                                   input out_word_t exp = '0);
    dir_row_t row;
    row.is_cfg = 1'b0; row.reg_idx = '0; row.reg_val = '0;
    row.w = w; row.typed = typed; row.exp = exp;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [6:0] val);
    dir_row_t row;
    row = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, w: '0, typed: 1'b0, exp: '0};
    dir_rows = {dir_rows, row};
  endfunction

  function automatic void build_directed();
    out_word_t no_hit, full_hit;
    no_hit   = '{hit_valid: 1'b0, prim_id: '0, last: 1'b1, stack_overflow: 1'b0};
    full_hit = '{hit_valid: 1'b1, prim_id: 20'hfffff, last: 1'b1,
                 stack_overflow: 1'b0};
    // empty trees right after reset, and a query on a nonexistent tree
    add_word(mk(OP_QUERY, TREE_V, 0, 0, 0, 0, 0, 0, 0, R_MAX), 1'b1, no_hit);
    add_word(mk(OP_QUERY, TREE_NONE, 0, C_MAX, C_MIN, 0, 0, 0, 0, 0), 1'b1, no_hit);
    // dropped words: unused opcode, bad tree, slot past the end
    add_word(mk(OP_NONE, TREE_V, 7'h7f, -1, -1, -1, 20'hfffff, 7'h7f, 1, R_MAX));
    add_word(mk(OP_LOAD_LO, TREE_NONE, 0, 0, 0, 0, 0, 0, 1, 0));
    add_word(mk(OP_LOAD_LO, TREE_V, 7'd127, 0, 0, 0, 0, 0, 1, 0));
    // one-node tree spanning the whole space, hit from both extremes
    add_cfg(REG_VERTEX_NODES, 7'd1);
    add_word(mk(OP_LOAD_LO, TREE_V, 0, C_MIN, C_MIN, C_MIN, 20'hfffff, 7'h7f, 1, 0));
    add_word(mk(OP_LOAD_HI, TREE_V, 0, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0));
    add_word(mk(OP_QUERY, TREE_V, 0, C_MAX, C_MAX, C_MAX, 0, 0, 0, R_MAX), 1'b1, full_hit);
    add_word(mk(OP_QUERY, TREE_V, 0, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0), 1'b1, full_hit);
    // self-looping inner root: both children overlap, stack overflows
    add_cfg(REG_EDGE_NODES, 7'd2);
    add_word(mk(OP_LOAD_LO, TREE_E, 0, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0));
    add_word(mk(OP_LOAD_HI, TREE_E, 0, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0));
    add_word(mk(OP_LOAD_LO, TREE_E, 1, 0, 0, 0, 20'd5, 0, 1, 0));
    add_word(mk(OP_LOAD_HI, TREE_E, 1, 0, 0, 0, 0, 0, 0, 0));
    add_word(mk(OP_QUERY, TREE_E, 0, 0, 0, 0, 0, 0, 0, 0));
    // root loops on itself and hits a leaf every step: more than 64 hits, then a query that misses the leaf
    add_cfg(REG_FACE_NODES, 7'd2);
    add_word(mk(OP_LOAD_LO, TREE_F, 0, C_MIN, C_MIN, C_MIN, 0, 7'd1, 0, 0));
    add_word(mk(OP_LOAD_HI, TREE_F, 0, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0));
    add_word(mk(OP_LOAD_LO, TREE_F, 1, -16, -16, 0, 20'habcde, 0, 1, 0));
    add_word(mk(OP_LOAD_HI, TREE_F, 1, 16, 16, 0, 0, 0, 0, 0));
    add_word(mk(OP_QUERY, TREE_F, 0, 0, 0, 0, 0, 0, 0, 30'd16));
    add_word(mk(OP_QUERY, TREE_F, 0, 100, 100, 0, 0, 0, 0, 30'd16));
  endfunction

  // Random node: heap-shaped links most of the time, junk links sometimes.
  task automatic load_node(input logic [1:0] tree, input int n, input int i,
                           input bit flat);
    int cx, cy, cz, h;
    logic [19:0] lp;
    logic [6:0] rl;
    logic leaf;
    in_word_t w;
    cx = int'($urandom_range(0, 2**21)) - 2**20;
    cy = int'($urandom_range(0, 2**21)) - 2**20;
    cz = flat ? 0 : int'($urandom_range(0, 2**21)) - 2**20;
    h  = $urandom_range(0, 2**19);
    if ($urandom_range(9) == 0) begin
      leaf = $urandom_range(1);
      lp = $urandom_range(1) ? 20'($urandom) : 20'($urandom_range(n - 1));
      rl = 7'($urandom_range(127));
    end else if (2 * i + 2 < n) begin
      leaf = 1'b0; lp = 20'(2 * i + 1); rl = 7'(2 * i + 2);
    end else begin
      leaf = 1'b1; lp = 20'($urandom); rl = 7'($urandom);
    end
    if ($urandom_range(19) == 0) begin
      // box that covers everything
      send_word(mk(OP_LOAD_LO, tree, 7'(i), C_MIN, C_MIN, C_MIN, lp, rl, leaf, 30'($urandom)),
                1'b0, '0);
      send_word(mk(OP_LOAD_HI, tree, 7'(i), C_MAX, C_MAX, C_MAX, 20'($urandom), 7'($urandom),
                   1'($urandom), 30'($urandom)), 1'b0, '0);
    end else begin
      w = mk(OP_LOAD_LO, tree, 7'(i), cx - h, cy - h, cz - (flat ? 0 : h), lp, rl, leaf,
             30'($urandom));
      send_word(w, 1'b0, '0);
      w = mk(OP_LOAD_HI, tree, 7'(i), cx + h, cy + h, cz + (flat ? 0 : h), 20'($urandom),
             7'($urandom), 1'($urandom), 30'($urandom));
      send_word(w, 1'b0, '0);
    end
  endtask

  task automatic random_query();
    int sel;
    in_word_t w;
    sel = $urandom_range(19);
    w = mk(OP_QUERY, 2'($urandom_range(2)), 7'($urandom),
           int'($urandom_range(0, 2**21)) - 2**20, int'($urandom_range(0, 2**21)) - 2**20,
           ($urandom_range(3) == 0) ? 0 : int'($urandom_range(0, 2**21)) - 2**20,
           20'($urandom), 7'($urandom), 1'($urandom), 30'($urandom_range(0, 2**19)));
    if (sel == 0) begin
      w.coord_x = $urandom; w.coord_y = $urandom; w.coord_z = $urandom;
      w.query_radius = 30'($urandom);
    end else if (sel == 1) begin
      w.query_radius = R_MAX - 30'($urandom_range(3));
    end else if (sel == 2) begin
      w.tree_select = TREE_NONE;
    end
    send_word(w, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: samples between edges, checks at the edge the word is taken,
  // drives out_ready for the next cycle.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    bit took;
    int hold;
    out_word_t got, want;
    hold = 0;
    forever begin
      @(negedge clk);
      took = out_valid && out_ready;
      got  = out_data;
      @(posedge clk);
      if (took) begin
        n_results++;
        if (pending_hits.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %p", got));
        end else begin
          want = pending_hits.pop_front();
          if (got.hit_valid !== want.hit_valid)
            report_mismatch($sformatf("hit_valid %b want %b", got.hit_valid, want.hit_valid));
          if (got.prim_id !== want.prim_id)
            report_mismatch($sformatf("prim_id %h want %h",
                                      got.prim_id, want.prim_id));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %b want %b", got.last, want.last));
          if (got.stack_overflow !== want.stack_overflow)
            report_mismatch($sformatf("stack_overflow %b want %b",
                                      got.stack_overflow, want.stack_overflow));
          if (want.hit_valid) n_hits++;
          if (want.stack_overflow) n_ovf++;
        end
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase, n, q_in_phase;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors = 0; n_queries = 0; n_words = 0; n_results = 0; n_hits = 0; n_ovf = 0;
    send_idle = 11;
    recv_idle = 56;
    hold_req  = 1'b0;
    foreach (node_cnt[i]) node_cnt[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_count(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].exp);
    end

    // Random phases: new node counts, fresh trees, then a batch of queries.
    phase = 0;
    while (n_words < ITEM_CNT) begin
      for (int t = 0; t < 3; t++) begin
        case ($urandom_range(9))
          0:       n = 0;
          1:       n = 1;
          2:       n = 2;
          default: n = $urandom_range(3, 15);
        endcase
        if (phase == 1 && t == 0) n = BIG_TREE;  // one deeper tree
        if (phase == 2 && t == 2) n = BIG_TREE - 1;
        write_count(2'(t), 7'(n));
        for (int i = 0; i < n; i++) load_node(2'(t), n, i, (t == 2) && (phase % 2 == 0));
      end
      if (phase == 1) hold_req = 1'b1;  // receiver stalls while queries keep coming
      q_in_phase = $urandom_range(15, 25);
      for (int j = 0; j < q_in_phase; j++) begin
        case ($urandom_range(15))
          0: send_word(mk(OP_NONE, 2'($urandom), 7'($urandom), $urandom, $urandom, $urandom,
                          20'($urandom), 7'($urandom), 1'($urandom), 30'($urandom)),
                       1'b0, '0);
          1: if (node_cnt[0] > 0) load_node(TREE_V, node_cnt[0], $urandom_range(node_cnt[0] - 1),
                                            1'b0);
          2: send_word(mk(2'($urandom_range(1)), TREE_NONE, 7'($urandom), $urandom, $urandom,
                          $urandom, 20'($urandom), 7'($urandom), 1'($urandom), 30'($urandom)),
                       1'b0, '0);
          default: random_query();
        endcase
      end
      phase++;
    end
    in_valid <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (pending_hits.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_hits.size()));
    $display("Covered %0d words (%0d queries) over %0d tree setups: %0d result words, %0d hits,",
             n_words, n_queries, phase, n_results, n_hits);
    $display("%0d words flagged overflow, with sender/receiver stalls and a long hold-off.",
             n_ovf);
    if (errors == 0) begin
      $display("tb_bvh_box_overlap_query_core OK");
    end else begin
      $display("tb_bvh_box_overlap_query_core NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #20000000;
    $display("tb_bvh_box_overlap_query_core NOT OK");
    $finish;
  end

endmodule

### files.f
design/bvh_pkg.sv
design/bvh_box_overlap_query_core.sv
dv/tb_bvh_box_overlap_query_core.sv
